>>> rtl/core/utf16_to_utf8_transcoder_defines.svh
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH
`define UTF16_TO_UTF8_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset
`define UTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Consequence that must hold in the cycle after the antecedent
`define UTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define UTT_ASSERT(lbl, prop, msg)
`define UTT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/utt_pkg.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: shared package
// Types and constants used by the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package utt_pkg;

  // Maximum number of UTF-8 bytes for one code point
  localparam int unsigned MaxBytes = 4;

  // One encoded code point: bytes in emission order, index of the final byte
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [1:0]               last_idx;
  } utt_entry_t;

  // Surrogate constants
  localparam logic [5:0]  SurrHighTag  = 6'b110110;
  localparam logic [20:0] Plane1Base   = 21'h10000;
  localparam logic [20:0] SurrLowBase  = 21'h0DC00;

  // Encoding length thresholds
  localparam logic [20:0] Max1Byte = 21'h00007F;
  localparam logic [20:0] Max2Byte = 21'h0007FF;
  localparam logic [20:0] Max3Byte = 21'h00FFFF;

endpackage

>>> rtl/core/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: top level
// Converts a stream of UTF-16 code units into a stream of UTF-8 bytes.
// ----------------------------------------------------------------------------
// Input stream s_axis: one code unit per request, tdata[7:0] the first raw
// byte and tdata[15:8] the second; tlast marks the final unit of the stream.
// Output stream m_axis: one UTF-8 byte per request, tlast on the last byte
// produced for an input unit. A high surrogate that is not final is held and
// produces nothing; the next unit is joined with it.
// Byte order comes from cfg_wdata_i, written when cfg_we_i is high (1 = big
// endian); write it only while the block is idle.
// A unit is registered in the queue, then byte by byte in the output
// register. Throughput: one output byte per cycle while m_axis_tready is
// high, set by the single output register of the back end; a unit gives 1 to
// 4 bytes according to its encoded length. The front end keeps accepting
// while the queue of QUEUE_DEPTH byte groups has room, so a stalled receiver
// backs up into the queue and then into s_axis_tready. Reset clears the held
// surrogate, the queue and the output register and selects little endian.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // big_endian
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
  input  logic        s_axis_tlast,   // final_unit
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] utf8_byte
  output logic        m_axis_tlast    // run_last
);
  import utt_pkg::*;

  logic       big_endian_q;
  logic       q_ready;
  logic       push;
  utt_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  utt_entry_t head;

  // Byte order register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      big_endian_q <= 1'b0;
    end else if (cfg_we_i) begin
      big_endian_q <= cfg_wdata_i;
    end
  end

  utt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .big_endian_i  (big_endian_q),
    .in_valid_i    (s_axis_tvalid),
    .first_byte_i  (s_axis_tdata[7:0]),
    .second_byte_i (s_axis_tdata[15:8]),
    .final_unit_i  (s_axis_tlast),
    .in_ready_o    (s_axis_tready),
    .q_ready_i     (q_ready),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  utt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  utt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_ready_i  (m_axis_tready)
  );

endmodule

>>> rtl/core/utt_front.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: front end
// Accepts code units, pairs surrogates and encodes each code point into the
// UTF-8 byte group that is pushed to the queue.
// ----------------------------------------------------------------------------
module utt_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               big_endian_i,
  input  logic               in_valid_i,
  input  logic [7:0]         first_byte_i,
  input  logic [7:0]         second_byte_i,
  input  logic               final_unit_i,
  output logic               in_ready_o,
  input  logic               q_ready_i,
  output logic               push_o,
  output utt_pkg::utt_entry_t push_entry_o
);
  import utt_pkg::*;

  logic        holding_q, holding_d;
  logic [15:0] held_q, held_d;
  logic [15:0] unit;
  logic        is_high;
  logic        accept;
  logic [20:0] cp_join;
  logic [20:0] cp;

  // Build the encoded byte group of one code point
  function automatic utt_entry_t encode(input logic [20:0] c);
    utt_entry_t e;
    e.bytes = '0;
    if (c <= Max1Byte) begin
      e.bytes[0] = c[7:0];
      e.last_idx = 2'd0;
    end else if (c <= Max2Byte) begin
      e.bytes[0] = {3'b110, c[10:6]};
      e.bytes[1] = {2'b10, c[5:0]};
      e.last_idx = 2'd1;
    end else if (c <= Max3Byte) begin
      e.bytes[0] = {4'b1110, c[15:12]};
      e.bytes[1] = {2'b10, c[11:6]};
      e.bytes[2] = {2'b10, c[5:0]};
      e.last_idx = 2'd2;
    end else begin
      e.bytes[0] = {5'b11110, c[20:18]};
      e.bytes[1] = {2'b10, c[17:12]};
      e.bytes[2] = {2'b10, c[11:6]};
      e.bytes[3] = {2'b10, c[5:0]};
      e.last_idx = 2'd3;
    end
    return e;
  endfunction

  // Assemble the unit in the configured byte order
  assign unit    = big_endian_i ? {first_byte_i, second_byte_i}
                                : {second_byte_i, first_byte_i};
  assign is_high = (unit[15:10] == SurrHighTag);

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Join with the held high surrogate; the sum always fits 21 bits
  assign cp_join = {1'b0, held_q[9:0], 10'd0} + Plane1Base + {5'd0, unit} - SurrLowBase;
  assign cp      = holding_q ? cp_join : {5'd0, unit};

  // Decide between hold and push
  always_comb begin
    holding_d    = holding_q;
    held_d       = held_q;
    push_o       = 1'b0;
    push_entry_o = encode(cp);
    if (accept) begin
      if (holding_q) begin
        holding_d = 1'b0;
        push_o    = 1'b1;
      end else if (is_high && !final_unit_i) begin
        holding_d = 1'b1;
        held_d    = unit;
      end else begin
        push_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q <= 1'b0;
      held_q    <= '0;
    end else begin
      holding_q <= holding_d;
      held_q    <= held_d;
    end
  end

endmodule

>>> rtl/core/utt_queue.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: decoupling queue
// Short queue of encoded byte groups between the front and back ends.
// ----------------------------------------------------------------------------
`include "utf16_to_utf8_transcoder_defines.svh"

module utt_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utt_pkg::utt_entry_t push_entry_i,
  output logic                ready_o,
  input  logic                pop_i,
  output logic                head_valid_o,
  output utt_pkg::utt_entry_t head_o
);
  import utt_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  utt_entry_t    store_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign ready_o      = (count_q != CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = store_q[rd_ptr_q];

  // Write the pushed group
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `UTT_ASSERT(a_count_bound, count_q <= CW'(DEPTH), "queue occupancy beyond depth")
  `UTT_ASSERT(a_pop_nonempty, pop_i |-> (count_q != '0), "pop from empty queue")
  `UTT_ASSERT_NEXT(a_push_grows, push_i && !pop_i, count_q == $past(count_q) + 1'b1, "push lost")

endmodule

>>> rtl/core/utt_back.sv
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 transcoder: back end
// Serialises each byte group onto the output stream, one byte per cycle
// while out_ready_i allows, through an output register.
// ----------------------------------------------------------------------------
module utt_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  utt_pkg::utt_entry_t head_i,
  output logic                pop_o,
  output logic                out_valid_o,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  input  logic                out_ready_i
);
  import utt_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       is_last;

  assign load    = !valid_q || out_ready_i;
  assign is_last = (idx_q == head_i.last_idx);

  // Take the next byte of the head group when the output register frees up
  always_comb begin
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = head_valid_i;
      if (head_valid_i) begin
        byte_d = head_i.bytes[idx_q];
        last_d = is_last;
        if (is_last) begin
          idx_d = '0;
          pop_o = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold payload while stalled
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule
